// ===== hw/rtl/pimu_pkg.sv =====
package pimu_pkg;

	localparam int DEF_MAX_TASKS   = 16;
	localparam int DEF_NUM_MUTEXES = 16;
	localparam int DEF_PRIO_BITS   = 8;

	localparam logic [1:0] REQ_CREATE = 2'd0;
	localparam logic [1:0] REQ_INIT   = 2'd1;
	localparam logic [1:0] REQ_TAKE   = 2'd2;
	localparam logic [1:0] REQ_GIVE   = 2'd3;

	localparam logic [2:0] RES_CREATED   = 3'd0;
	localparam logic [2:0] RES_INITED    = 3'd1;
	localparam logic [2:0] RES_GRANTED   = 3'd2;
	localparam logic [2:0] RES_BLOCKED   = 3'd3;
	localparam logic [2:0] RES_RELEASED  = 3'd4;
	localparam logic [2:0] RES_NOT_OWNER = 3'd5;

	localparam logic [1:0] TS_READY = 2'd1;
	localparam logic [1:0] TS_WAIT  = 2'd2;

	// Folds a 4-bit index into the range 0 .. n-1 by repeated subtraction.
	function automatic logic [3:0] wrap_idx(input logic [3:0] v, input int unsigned n);
		logic [4:0] r;
		r = {1'b0, v};
		if (n == 1) begin
			r = '0;
		end else begin
			for (int k = 0; k < 8; k++) begin
				if (32'(r) >= n) begin
					r = r - 5'(n);
				end
			end
		end
		return r[3:0];
	endfunction

endpackage

// ===== hw/rtl/priority_inheritance_mutex_unit_core.sv =====
// Create, init, a granted take and a refused give go from S_EVAL to S_DONE to put their result
// out, a blocked take also passes S_OWN, and a give by the owner passes S_WAKE and S_INH:
// it makes two passes over the task memory, one entry per cycle.
// One request is in work at a time; the next is accepted the cycle after its result moves to
// the output register.
// Reset is asynchronous and clears both tables at once through per-entry valid bits.
module priority_inheritance_mutex_unit_core import pimu_pkg::*; #(
	parameter int MAX_TASKS   = DEF_MAX_TASKS,
	parameter int NUM_MUTEXES = DEF_NUM_MUTEXES,
	parameter int PRIO_BITS   = DEF_PRIO_BITS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] req_type,
	input  logic [3:0] task_id,
	input  logic [3:0] mutex_id,
	input  logic [7:0] priority_req,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] status,
	output logic       yield_needed,
	output logic [7:0] task_priority,
	output logic [3:0] holder_task,
	output logic       holder_valid
);

	localparam int TW = $clog2(MAX_TASKS);
	localparam int MW = (NUM_MUTEXES > 1) ? $clog2(NUM_MUTEXES) : 1;
	localparam int PW = PRIO_BITS;
	localparam int CW = $clog2(MAX_TASKS + 1);

	typedef struct packed {
		logic [1:0]    st;
		logic [PW-1:0] base;
		logic [PW-1:0] eff;
		logic [MW-1:0] wmtx;
		logic          wv;
	} task_ent_t;

	typedef struct packed {
		logic          held;
		logic [TW-1:0] owner;
	} mtx_ent_t;

	localparam int TEW = $bits(task_ent_t);
	localparam int MEW = $bits(mtx_ent_t);

	typedef enum logic [2:0] {
		S_IDLE, S_EVAL, S_OWN, S_WAKE, S_INH, S_DONE
	} state_t;

	state_t        state_q;
	logic [1:0]    req_q;
	logic [TW-1:0] t_q;
	logic [TW-1:0] o_q;
	logic [MW-1:0] m_q;
	logic [PW-1:0] prio_q;
	task_ent_t     tent_q;
	logic [PW-1:0] best_q;
	logic          yld_q;
	logic [CW-1:0] cnt_q;
	logic          v_s1;
	logic [TW-1:0] idx_s1;
	logic          v_s2;
	logic [PW-1:0] eff_s2;

	logic [2:0]    res_status_q;
	logic          res_yld_q;
	logic [PW-1:0] res_prio_q;
	logic [TW-1:0] res_hold_q;
	logic          res_hv_q;

	logic          out_valid_q;
	logic [2:0]    status_q;
	logic          yield_q;
	logic [PW-1:0] prio_out_q;
	logic [TW-1:0] hold_q;
	logic          hv_q;

	logic [TW-1:0]  in_t;
	logic [MW-1:0]  in_m;
	logic           t_we;
	logic [TW-1:0]  t_waddr;
	task_ent_t      t_wdata;
	logic [TW-1:0]  t_raddr;
	logic [TEW-1:0] t_rdata;
	task_ent_t      t_rd;
	logic           m_we;
	logic [MW-1:0]  m_waddr;
	mtx_ent_t       m_wdata;
	logic [MW-1:0]  m_raddr;
	logic [MEW-1:0] m_rdata;
	mtx_ent_t       m_rd;

	logic          owns;
	logic          cnt_run;
	logic [TW-1:0] cnt_idx;
	logic          wake_hit;
	logic          inh_end;

	assign in_t    = TW'(wrap_idx(task_id, MAX_TASKS));
	assign in_m    = MW'(wrap_idx(mutex_id, NUM_MUTEXES));
	assign t_rd    = t_rdata;
	assign m_rd    = m_rdata;
	assign owns    = m_rd.held && (m_rd.owner == t_q);
	assign cnt_run = (cnt_q < CW'(MAX_TASKS));
	assign cnt_idx = cnt_q[TW-1:0];
	assign wake_hit = v_s1 && (t_rd.st == TS_WAIT) && t_rd.wv && (t_rd.wmtx == m_q);
	assign inh_end = !cnt_run && !v_s1 && !v_s2;

	pimu_ram #(.DEPTH(MAX_TASKS), .WIDTH(TEW)) u_task_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (t_we),
		.waddr  (t_waddr),
		.wdata  (t_wdata),
		.raddr  (t_raddr),
		.rdata  (t_rdata)
	);

	pimu_ram #(.DEPTH(NUM_MUTEXES), .WIDTH(MEW)) u_mtx_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (m_we),
		.waddr  (m_waddr),
		.wdata  (m_wdata),
		.raddr  (m_raddr),
		.rdata  (m_rdata)
	);

	// Memory port control. Reads are registered in the RAM; the sequence never reads an
	// entry in the same cycle that it writes it, except where the old value is wanted.
	always_comb begin
		t_we    = 1'b0;
		t_waddr = t_q;
		t_wdata = t_rd;
		t_raddr = '0;
		m_we    = 1'b0;
		m_waddr = m_q;
		m_wdata = '0;
		m_raddr = '0;
		unique case (state_q)
			S_IDLE: begin
				t_raddr = in_t;
				m_raddr = in_m;
			end
			S_EVAL: begin
				unique case (req_q)
					REQ_CREATE: begin
						t_we    = 1'b1;
						t_wdata = '{st: TS_READY, base: prio_q, eff: prio_q, wmtx: '0, wv: 1'b0};
					end
					REQ_INIT: begin
						m_we = 1'b1;
					end
					REQ_TAKE: begin
						t_we = 1'b1;
						if (!m_rd.held) begin
							m_we         = 1'b1;
							m_wdata      = '{held: 1'b1, owner: t_q};
							t_wdata.wmtx = '0;
							t_wdata.wv   = 1'b0;
						end else begin
							t_wdata.st   = TS_WAIT;
							t_wdata.wmtx = m_q;
							t_wdata.wv   = 1'b1;
							t_raddr      = m_rd.owner;
						end
					end
					REQ_GIVE: begin
						m_we = owns;
					end
					default: begin
					end
				endcase
			end
			S_OWN: begin
				// Priority inheritance: lift the owner to the blocked taker's level.
				t_waddr     = o_q;
				t_we        = (tent_q.eff > t_rd.eff);
				t_wdata.eff = tent_q.eff;
			end
			S_WAKE: begin
				t_raddr      = cnt_idx;
				t_waddr      = idx_s1;
				t_we         = wake_hit;
				t_wdata.st   = TS_READY;
				t_wdata.wmtx = '0;
				t_wdata.wv   = 1'b0;
			end
			S_INH: begin
				t_raddr     = cnt_idx;
				m_raddr     = t_rd.wmtx;
				t_we        = inh_end;
				t_wdata     = tent_q;
				t_wdata.eff = best_q;
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			req_q        <= REQ_CREATE;
			t_q          <= '0;
			o_q          <= '0;
			m_q          <= '0;
			prio_q       <= '0;
			tent_q       <= '0;
			best_q       <= '0;
			yld_q        <= 1'b0;
			cnt_q        <= '0;
			v_s1         <= 1'b0;
			idx_s1       <= '0;
			v_s2         <= 1'b0;
			eff_s2       <= '0;
			res_status_q <= RES_CREATED;
			res_yld_q    <= 1'b0;
			res_prio_q   <= '0;
			res_hold_q   <= '0;
			res_hv_q     <= 1'b0;
			out_valid_q  <= 1'b0;
			status_q     <= RES_CREATED;
			yield_q      <= 1'b0;
			prio_out_q   <= '0;
			hold_q       <= '0;
			hv_q         <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						req_q   <= req_type;
						t_q     <= in_t;
						m_q     <= in_m;
						prio_q  <= PW'(priority_req);
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					tent_q <= t_rd;
					unique case (req_q)
						REQ_CREATE: begin
							res_status_q <= RES_CREATED;
							res_yld_q    <= 1'b0;
							res_prio_q   <= prio_q;
							res_hold_q   <= m_rd.owner;
							res_hv_q     <= m_rd.held;
							state_q      <= S_DONE;
						end
						REQ_INIT: begin
							res_status_q <= RES_INITED;
							res_yld_q    <= 1'b0;
							res_prio_q   <= t_rd.eff;
							res_hold_q   <= '0;
							res_hv_q     <= 1'b0;
							state_q      <= S_DONE;
						end
						REQ_TAKE: begin
							res_yld_q  <= m_rd.held;
							res_prio_q <= t_rd.eff;
							res_hv_q   <= 1'b1;
							if (!m_rd.held) begin
								res_status_q <= RES_GRANTED;
								res_hold_q   <= t_q;
								state_q      <= S_DONE;
							end else begin
								res_status_q <= RES_BLOCKED;
								res_hold_q   <= m_rd.owner;
								o_q          <= m_rd.owner;
								state_q      <= S_OWN;
							end
						end
						REQ_GIVE: begin
							if (owns) begin
								yld_q   <= 1'b0;
								best_q  <= t_rd.base;
								cnt_q   <= '0;
								v_s1    <= 1'b0;
								v_s2    <= 1'b0;
								state_q <= S_WAKE;
							end else begin
								res_status_q <= RES_NOT_OWNER;
								res_yld_q    <= 1'b0;
								res_prio_q   <= t_rd.eff;
								res_hold_q   <= m_rd.owner;
								res_hv_q     <= m_rd.held;
								state_q      <= S_DONE;
							end
						end
						default: begin
							state_q <= S_DONE;
						end
					endcase
				end
				S_OWN: begin
					state_q <= S_DONE;
				end
				S_WAKE: begin
					v_s1   <= cnt_run;
					idx_s1 <= cnt_idx;
					if (cnt_run) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (wake_hit && (t_rd.eff > tent_q.eff)) begin
						yld_q <= 1'b1;
					end
					if (!cnt_run && !v_s1) begin
						cnt_q   <= '0;
						state_q <= S_INH;
					end
				end
				S_INH: begin
					// Stage one has the task entry and reads its awaited mutex;
					// stage two checks whether the giver still owns that mutex.
					v_s1   <= cnt_run;
					idx_s1 <= cnt_idx;
					if (cnt_run) begin
						cnt_q <= cnt_q + 1'b1;
					end
					v_s2   <= v_s1 && (t_rd.st == TS_WAIT) && t_rd.wv;
					eff_s2 <= t_rd.eff;
					if (v_s1 && (idx_s1 == t_q)) begin
						tent_q <= t_rd;
					end
					if (v_s2 && m_rd.held && (m_rd.owner == t_q) && (eff_s2 > best_q)) begin
						best_q <= eff_s2;
					end
					if (inh_end) begin
						res_status_q <= RES_RELEASED;
						res_yld_q    <= yld_q;
						res_prio_q   <= best_q;
						res_hold_q   <= '0;
						res_hv_q     <= 1'b0;
						state_q      <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						status_q    <= res_status_q;
						yield_q     <= res_yld_q;
						prio_out_q  <= res_prio_q;
						hold_q      <= res_hold_q;
						hv_q        <= res_hv_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready      = (state_q == S_IDLE);
	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign yield_needed  = yield_q;
	assign task_priority = 8'(prio_out_q);
	assign holder_task   = 4'(hold_q);
	assign holder_valid  = hv_q;

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (!t_we && !m_we))
		else $error("table written while no request is in work");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_TASKS))
		else $error("scan counter ran past the task table");

	a_blocked_yield: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == RES_BLOCKED)) |-> (yield_needed && holder_valid))
		else $error("blocked result without yield or owner");

	a_release_free: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == RES_RELEASED)) |-> !holder_valid)
		else $error("released mutex still reports an owner");

endmodule

// ===== hw/rtl/pimu_ram.sv =====
module pimu_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// An entry never written since reset reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (we) begin
			vld_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= vld_q[raddr] ? mem_q[raddr] : '0;
	end

	assign rdata = rdata_q;

endmodule
